/* sv/sls_pkg.sv */
package sls_pkg;

    localparam int TABLE_ENTRIES = 40;
    localparam int MAX_PER_LINE  = 10;
    localparam int FIELDS        = 4;
    localparam int TABLE_BYTES   = TABLE_ENTRIES * FIELDS;
    localparam int ROW_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(MAX_PER_LINE + 1);

    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_READ  = 2'd1;
    localparam logic [1:0] FN_SCAN  = 2'd2;

    localparam logic [1:0] FLD_Y    = 2'd0;
    localparam logic [1:0] FLD_X    = 2'd1;
    localparam logic [1:0] FLD_TILE = 2'd2;
    localparam logic [1:0] FLD_ATTR = 2'd3;

    localparam logic CFG_TALL  = 1'b0;
    localparam logic CFG_ORDER = 1'b1;

    localparam logic [8:0] LINE_OFFSET  = 9'd16;
    localparam logic [8:0] SHORT_HEIGHT = 9'd8;
    localparam logic [8:0] TALL_HEIGHT  = 9'd16;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] byte_addr;
        logic [7:0] write_data;
        logic [7:0] scan_line;
    } t_in_word;

    typedef struct packed {
        logic       found;
        logic [7:0] sprite_x;
        logic [7:0] sprite_y;
        logic [7:0] tile_number;
        logic [7:0] attributes;
        logic [5:0] entry_index;
        logic [3:0] match_count;
        logic       last;
        logic [7:0] read_data;
    } t_out_word;

    typedef struct packed {
        logic [7:0]       x;
        logic [7:0]       y;
        logic [7:0]       tile;
        logic [7:0]       attr;
        logic [ROW_W-1:0] index;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_INSERT,
        CELL_SHIFT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      index_order;
        t_entry    new_entry;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    function automatic logic goes_after(t_entry a, t_entry b, logic index_order);
        logic res;
        if (index_order || (a.x == b.x)) begin
            res = a.index > b.index;
        end else begin
            res = a.x > b.x;
        end
        return res;
    endfunction

endpackage

/* sv/sls_ram.sv */
module sls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

/* sv/sls_cell.sv */
module sls_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sls_pkg::t_cell_ctrl i_ctrl,
    input  sls_pkg::t_entry     i_prev_entry,
    input  logic                i_prev_valid,
    input  logic                i_prev_before,
    input  sls_pkg::t_entry     i_next_entry,
    input  logic                i_next_valid,
    output sls_pkg::t_entry     o_entry,
    output logic                o_valid,
    output logic                o_before
);

    import sls_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   r_valid;
    logic   n_valid;

    assign o_before = !r_valid || goes_after(r_entry, i_ctrl.new_entry, i_ctrl.index_order);

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        case (i_ctrl.cmd)
            CELL_CLEAR: begin
                n_valid = 1'b0;
            end
            CELL_INSERT: begin
                if (o_before) begin
                    n_valid = i_prev_before ? i_prev_valid : 1'b1;
                    n_entry = i_prev_before ? i_prev_entry : i_ctrl.new_entry;
                end
            end
            CELL_SHIFT: begin
                n_valid = i_next_valid;
                n_entry = i_next_entry;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

/* sv/sprite_line_selection.sv */
// Sprite line selection: a 40-entry sprite attribute table with a line scan.
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one request word:
// write a table byte, read a table byte, or scan a display line.
// Output channel (o_out_valid / i_out_ready / o_out_word) returns result words.
// A write returns nothing. A read returns one word once the field memory
// output is registered and the output register is free. A scan fetches one
// table entry per cycle from the four byte-wide field memories; once the
// whole table is fetched it returns results from the head of the selection
// chain, one per cycle while the receiver takes them, ten at most; a scan
// with no hit returns one word with found clear.
// Selected sprites are sorted on the fly by a chain of ten cells as they are
// found. One request is handled at a time; a new one is taken once the
// previous results sit in the output register.
// When the receiver stalls, the output register holds its word and the
// emission halts until it is taken.
// Reset (synchronous, active low) clears the table to zero through per-byte
// valid bits, empties the chain, sets tall_sprites to 0 and index_order to 1.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
module sprite_line_selection (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sls_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sls_pkg::t_out_word o_out_word,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic              i_cfg_data
);

    import sls_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PER_LINE);

    t_state r_state;
    t_state n_state;

    logic r_tall;
    logic r_index_order;

    logic [TABLE_ENTRIES-1:0] r_vld [FIELDS];
    logic [FIELDS-1:0]        r_rd_vld;
    logic                     r_rd_ok;
    logic [1:0]               r_rd_field;

    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] r_pend_row;
    logic             r_pend;
    logic [7:0]       r_line;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_sent;

    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word w_out_next;
    logic      w_load;
    logic      w_out_free;

    logic             w_accept;
    logic             w_in_range;
    logic             w_wr;
    logic [ROW_W-1:0] w_in_row;
    logic             w_rd_en;
    logic [ROW_W-1:0] w_rd_row;
    logic [7:0]       w_q [FIELDS];
    logic [7:0]       w_fb [FIELDS];
    logic             w_match;
    logic             w_take;
    logic [8:0]       w_target;
    logic [8:0]       w_y9;
    logic [8:0]       w_y_end;
    logic             w_last_sent;

    t_cell_ctrl               w_ctrl;
    t_entry                   w_new;
    t_entry                   w_entry [MAX_PER_LINE];
    logic [MAX_PER_LINE-1:0]  w_valid;
    logic [MAX_PER_LINE-1:0]  w_before;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = int'(i_in_word.byte_addr) < TABLE_BYTES;
    assign w_in_row   = ROW_W'(i_in_word.byte_addr >> 2);
    assign w_wr       = w_accept && (i_in_word.func == FN_WRITE) && w_in_range;
    assign w_out_free = !r_out_valid || i_out_ready;

    for (genvar f = 0; f < FIELDS; f++) begin : g_field
        sls_ram #(
            .WIDTH(8),
            .DEPTH(TABLE_ENTRIES)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_wr && (i_in_word.byte_addr[1:0] == 2'(f))),
            .i_waddr(w_in_row),
            .i_wdata(i_in_word.write_data),
            .i_re   (w_rd_en),
            .i_raddr(w_rd_row),
            .o_rdata(w_q[f])
        );
        assign w_fb[f] = r_rd_vld[f] ? w_q[f] : 8'd0;
    end

    assign w_target = {1'b0, r_line} + LINE_OFFSET;
    assign w_y9     = {1'b0, w_fb[FLD_Y]};
    assign w_y_end  = w_y9 + (r_tall ? TALL_HEIGHT : SHORT_HEIGHT);
    assign w_match  = (w_target >= w_y9) && (w_target < w_y_end);
    assign w_take   = r_pend && w_match && (r_count < MAX_CNT);

    assign w_new.x     = w_fb[FLD_X];
    assign w_new.y     = w_fb[FLD_Y];
    assign w_new.tile  = w_fb[FLD_TILE];
    assign w_new.attr  = w_fb[FLD_ATTR];
    assign w_new.index = r_pend_row;

    assign w_last_sent = (r_sent + CNT_W'(1)) == r_count;

    for (genvar k = 0; k < MAX_PER_LINE; k++) begin : g_cell
        t_entry w_prev_entry;
        logic   w_prev_valid;
        logic   w_prev_before;
        t_entry w_next_entry;
        logic   w_next_valid;

        if (k == 0) begin : g_head
            assign w_prev_entry  = '0;
            assign w_prev_valid  = 1'b0;
            assign w_prev_before = 1'b0;
        end else begin : g_body
            assign w_prev_entry  = w_entry[k-1];
            assign w_prev_valid  = w_valid[k-1];
            assign w_prev_before = w_before[k-1];
        end

        if (k == MAX_PER_LINE - 1) begin : g_tail
            assign w_next_entry = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_mid
            assign w_next_entry = w_entry[k+1];
            assign w_next_valid = w_valid[k+1];
        end

        sls_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_entry (w_prev_entry),
            .i_prev_valid (w_prev_valid),
            .i_prev_before(w_prev_before),
            .i_next_entry (w_next_entry),
            .i_next_valid (w_next_valid),
            .o_entry      (w_entry[k]),
            .o_valid      (w_valid[k]),
            .o_before     (w_before[k])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_word.func)
                        FN_READ: n_state = ST_READ;
                        FN_SCAN: n_state = ST_SCAN;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_row == LAST_ROW) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free && ((r_count == '0) || w_last_sent)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready            = 1'b0;
        w_rd_en               = 1'b0;
        w_rd_row              = r_row;
        w_load                = 1'b0;
        w_out_next            = '0;
        w_ctrl.cmd            = CELL_HOLD;
        w_ctrl.index_order    = r_index_order;
        w_ctrl.new_entry      = w_new;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                w_rd_row   = w_in_row;
                if (w_accept && (i_in_word.func == FN_READ)) begin
                    w_rd_en = w_in_range;
                end
                if (w_accept && (i_in_word.func == FN_SCAN)) begin
                    w_ctrl.cmd = CELL_CLEAR;
                end
            end
            ST_READ: begin
                w_load               = w_out_free;
                w_out_next.last      = 1'b1;
                w_out_next.read_data = r_rd_ok ? w_fb[r_rd_field] : 8'd0;
            end
            ST_SCAN: begin
                w_rd_en = 1'b1;
                if (w_take) begin
                    w_ctrl.cmd = CELL_INSERT;
                end
            end
            ST_DRAIN: begin
                if (w_take) begin
                    w_ctrl.cmd = CELL_INSERT;
                end
            end
            ST_EMIT: begin
                w_load = w_out_free;
                if (r_count == '0) begin
                    w_out_next.last = 1'b1;
                end else begin
                    w_out_next.found       = 1'b1;
                    w_out_next.sprite_x    = w_entry[0].x;
                    w_out_next.sprite_y    = w_entry[0].y;
                    w_out_next.tile_number = w_entry[0].tile;
                    w_out_next.attributes  = w_entry[0].attr;
                    w_out_next.entry_index = 6'(w_entry[0].index);
                    w_out_next.match_count = 4'(r_count);
                    w_out_next.last        = w_last_sent;
                    if (w_out_free) begin
                        w_ctrl.cmd = CELL_SHIFT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_tall        <= 1'b0;
            r_index_order <= 1'b1;
            r_pend        <= 1'b0;
            r_count       <= '0;
            r_sent        <= '0;
            r_row         <= '0;
            r_out_valid   <= 1'b0;
            for (int f = 0; f < FIELDS; f++) begin
                r_vld[f] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TALL:  r_tall        <= i_cfg_data;
                    CFG_ORDER: r_index_order <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_wr) begin
                r_vld[i_in_word.byte_addr[1:0]][w_in_row] <= 1'b1;
            end
            r_pend <= (r_state == ST_SCAN);
            if (r_state == ST_SCAN) begin
                r_row <= r_row + ROW_W'(1);
            end
            if (w_accept && (i_in_word.func == FN_SCAN)) begin
                r_count <= '0;
                r_sent  <= '0;
                r_row   <= '0;
            end
            if (w_take) begin
                r_count <= r_count + CNT_W'(1);
            end
            if ((r_state == ST_EMIT) && w_out_free && (r_count != '0)) begin
                r_sent <= r_sent + CNT_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            for (int f = 0; f < FIELDS; f++) begin
                r_rd_vld[f] <= r_vld[f][w_rd_row];
            end
        end
        if (r_state == ST_IDLE) begin
            r_rd_ok    <= w_in_range;
            r_rd_field <= i_in_word.byte_addr[1:0];
        end
        if (r_state == ST_SCAN) begin
            r_pend_row <= r_row;
        end
        if (w_accept && (i_in_word.func == FN_SCAN)) begin
            r_line <= i_in_word.scan_line;
        end
        if (w_load) begin
            r_out_word <= w_out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("selection count above limit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_DRAIN) |-> ($countones(w_valid) == int'(r_count)))
        else $error("occupied cells disagree with selection count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.found) |-> (o_out_word.match_count != 4'd0))
        else $error("found word with zero match count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_word.func == FN_SCAN)) |=> (r_state == ST_SCAN && w_valid == '0))
        else $error("scan did not start from an empty chain");

endmodule
